/* sv/fca_pkg.sv */
package fca_pkg;

   // table geometry
   localparam int TABLE_DEPTH  = 4096;
   localparam int CHAIN_LENGTH = 10;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int STEP_W       = $clog2(CHAIN_LENGTH);
   localparam int CNT_W        = $clog2(CHAIN_LENGTH + 1);

   // field widths
   localparam int CLUSTER_W  = 24;
   localparam int INDEX_W    = 12;
   localparam int REQ_TYPE_W = 2;
   localparam int POS_W      = 4;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 4;

   localparam logic [CLUSTER_W-1:0] DEPTH_C = CLUSTER_W'(TABLE_DEPTH);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_ALLOC = 2'd2,
      REQ_WALK  = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_NO_SPACE     = 2'd1,
      STAT_OUT_OF_RANGE = 2'd2
   } status_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EMPTY_MARKER = 4'd0,
      CSR_END_MARKER   = 4'd1
   } csr_code_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0] empty_marker;
      logic [CLUSTER_W-1:0] end_marker;
   } cfg_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [CLUSTER_W-1:0] wr_data;
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [POS_W-1:0]     position;
      logic [CLUSTER_W-1:0] cluster;
      logic [STATUS_W-1:0]  status;
      logic                 last;
   } rsp_item_type;

endpackage

/* sv/fca_if.sv */
interface fca_req_if;
   logic                                valid;
   logic                                ready;
   logic [fca_pkg::REQ_TYPE_W-1:0]      req_type;
   logic [fca_pkg::INDEX_W-1:0]         index;
   logic [fca_pkg::CLUSTER_W-1:0]       value;

   modport source (output valid, req_type, index, value, input ready);
   modport sink   (input valid, req_type, index, value, output ready);
endinterface

interface fca_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [fca_pkg::POS_W-1:0]           position;
   logic [fca_pkg::CLUSTER_W-1:0]       cluster;
   logic [fca_pkg::STATUS_W-1:0]        status;
   logic                                last;

   modport source (output valid, position, cluster, status, last, input ready);
   modport sink   (input valid, position, cluster, status, last, output ready);
endinterface

interface fca_csr_if;
   logic                                valid;
   logic                                ready;
   logic [fca_pkg::CSR_IDX_W-1:0]       index;
   logic [fca_pkg::CLUSTER_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/fca_ram.sv */
module fca_ram (
   input  logic                          clock,
   input  fca_pkg::mem_req_type          mem_req,
   output logic [fca_pkg::CLUSTER_W-1:0] rd_data
);

   logic [fca_pkg::CLUSTER_W-1:0] link_mem_ff [fca_pkg::TABLE_DEPTH];
   logic [fca_pkg::CLUSTER_W-1:0] rd_data_ff;

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         link_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= link_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fca_seq.sv */
module fca_seq (
   input  logic                          clock,
   input  logic                          reset,
   fca_req_if.sink                       req,
   fca_rsp_if.source                     rsp,
   input  fca_pkg::cfg_type              cfg,
   output fca_pkg::mem_req_type          mem_req,
   input  logic [fca_pkg::CLUSTER_W-1:0] rd_data
);

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_READ      = 8'b0000_0100,
      ST_SCAN      = 8'b0000_1000,
      ST_FAIL      = 8'b0001_0000,
      ST_LINK      = 8'b0010_0000,
      ST_WALK      = 8'b0100_0000,
      ST_WALK_WAIT = 8'b1000_0000
   } state_type;

   localparam logic [fca_pkg::ADDR_W:0] SCAN_END = (fca_pkg::ADDR_W + 1)'(fca_pkg::TABLE_DEPTH);
   localparam logic [fca_pkg::ADDR_W-1:0] CLR_LAST =
      fca_pkg::ADDR_W'(fca_pkg::TABLE_DEPTH - 1);
   localparam logic [fca_pkg::STEP_W-1:0] STEP_LAST =
      fca_pkg::STEP_W'(fca_pkg::CHAIN_LENGTH - 1);
   localparam logic [fca_pkg::CNT_W-1:0] CNT_FULL = fca_pkg::CNT_W'(fca_pkg::CHAIN_LENGTH);

   state_type                     state_ff, state_in;
   logic [fca_pkg::ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [fca_pkg::ADDR_W:0]      scan_addr_ff, scan_addr_in;
   logic                          pend_ff, pend_in;
   logic [fca_pkg::ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic [fca_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [fca_pkg::ADDR_W-1:0]    found_ff [fca_pkg::CHAIN_LENGTH];
   logic [fca_pkg::ADDR_W-1:0]    found_in [fca_pkg::CHAIN_LENGTH];
   logic [fca_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [fca_pkg::CLUSTER_W-1:0] cur_ff, cur_in;
   logic                          broken_ff, broken_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   fca_pkg::rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                          out_free;
   logic                          out_load;
   logic                          hit;
   logic [fca_pkg::CNT_W-1:0]     cnt_nxt;
   logic                          step_last;
   logic [fca_pkg::STEP_W-1:0]    step_nxt;
   logic                          idx_ok;

   function automatic fca_pkg::rsp_item_type mk_item(
      input logic [fca_pkg::STEP_W-1:0]    pos,
      input logic [fca_pkg::CLUSTER_W-1:0] clus,
      input fca_pkg::status_code_type      stat,
      input logic                          fin
   );
      fca_pkg::rsp_item_type item;
      item.position = fca_pkg::POS_W'(pos);
      item.cluster  = clus;
      item.status   = stat;
      item.last     = fin;
      return item;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign hit       = pend_ff && (rd_data == cfg.empty_marker);
   assign cnt_nxt   = cnt_ff + fca_pkg::CNT_W'(hit);
   assign step_last = (step_ff == STEP_LAST);
   assign step_nxt  = step_last ? '0 : step_ff + 1'b1;
   assign idx_ok    = fca_pkg::CLUSTER_W'(req.index) < fca_pkg::DEPTH_C;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      broken_in    = broken_ff;
      rsp_item_in  = rsp_item_ff;
      out_load     = 1'b0;
      mem_req      = '0;
      req.ready    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_ff;
            mem_req.wr_data = '0;
            clr_addr_in     = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = out_free;
            if (req.valid && out_free) begin
               case (req.req_type)
                  fca_pkg::REQ_WRITE: begin
                     out_load = 1'b1;
                     if (idx_ok) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = fca_pkg::ADDR_W'(req.index);
                        mem_req.wr_data = req.value;
                        rsp_item_in     = mk_item('0, req.value, fca_pkg::STAT_OK, 1'b1);
                     end else begin
                        rsp_item_in = mk_item('0, '0, fca_pkg::STAT_OUT_OF_RANGE, 1'b1);
                     end
                  end
                  fca_pkg::REQ_READ: begin
                     if (idx_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = fca_pkg::ADDR_W'(req.index);
                        state_in        = ST_READ;
                     end else begin
                        out_load    = 1'b1;
                        rsp_item_in = mk_item('0, '0, fca_pkg::STAT_OUT_OF_RANGE, 1'b1);
                     end
                  end
                  fca_pkg::REQ_ALLOC: begin
                     scan_addr_in = '0;
                     cnt_in       = '0;
                     pend_in      = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                     // walk: first result is the start cluster itself
                     out_load    = 1'b1;
                     rsp_item_in = mk_item('0, fca_pkg::CLUSTER_W'(req.index),
                                           fca_pkg::STAT_OK, 1'b0);
                     cur_in      = fca_pkg::CLUSTER_W'(req.index);
                     broken_in   = 1'b0;
                     step_in     = fca_pkg::STEP_W'(1);
                     state_in    = ST_WALK;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_item_in = mk_item('0, rd_data, fca_pkg::STAT_OK, 1'b1);
               state_in    = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, its data compared in the next cycle
            if (hit) begin
               found_in[cnt_ff[fca_pkg::STEP_W-1:0]] = pend_addr_ff;
            end
            cnt_in = cnt_nxt;
            if (cnt_nxt == CNT_FULL) begin
               pend_in  = 1'b0;
               step_in  = '0;
               state_in = ST_LINK;
            end else if (scan_addr_ff < SCAN_END) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_addr_ff[fca_pkg::ADDR_W-1:0];
               pend_in         = 1'b1;
               pend_addr_in    = scan_addr_ff[fca_pkg::ADDR_W-1:0];
               scan_addr_in    = scan_addr_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_FAIL;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_item_in = mk_item('0, '0, fca_pkg::STAT_NO_SPACE, 1'b1);
               state_in    = ST_IDLE;
            end
         end
         ST_LINK: begin
            if (out_free) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = found_ff[step_ff];
               mem_req.wr_data = step_last ? cfg.end_marker
                                           : fca_pkg::CLUSTER_W'(found_ff[step_nxt]);
               out_load        = 1'b1;
               rsp_item_in     = mk_item(step_ff, fca_pkg::CLUSTER_W'(found_ff[step_ff]),
                                         fca_pkg::STAT_OK, step_last);
               step_in         = step_nxt;
               if (step_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            if (broken_ff || (cur_ff >= fca_pkg::DEPTH_C)) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  rsp_item_in = mk_item(step_ff, '0, fca_pkg::STAT_OUT_OF_RANGE, step_last);
                  broken_in   = 1'b1;
                  step_in     = step_nxt;
                  if (step_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cur_ff[fca_pkg::ADDR_W-1:0];
               state_in        = ST_WALK_WAIT;
            end
         end
         ST_WALK_WAIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_item_in = mk_item(step_ff, rd_data, fca_pkg::STAT_OK, step_last);
               cur_in      = rd_data;
               step_in     = step_nxt;
               state_in    = step_last ? ST_IDLE : ST_WALK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         scan_addr_ff <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         broken_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         scan_addr_ff <= scan_addr_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         broken_ff    <= broken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      found_ff     <= found_in;
      cur_ff       <= cur_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.position = rsp_item_ff.position;
   assign rsp.cluster  = rsp_item_ff.cluster;
   assign rsp.status   = rsp_item_ff.status;
   assign rsp.last     = rsp_item_ff.last;

   // no request taken while the table is being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request accepted during clearing pass");

   // single memory port: never read and write in one cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("memory read and write in same cycle");

   // found count stays below the chain length while scanning
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff < CNT_FULL))
      else $error("scan count overflow");

   // a broken walk never touches the table again
   a_broken_no_read: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && broken_ff) |-> !mem_req.rd_en)
      else $error("broken walk issued a read");

   // a result is never overwritten while waiting
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !out_load)
      else $error("pending result overwritten");

endmodule

/* sv/fat_chain_allocator.sv */
// File allocation table of 4096 links, 24 bits each, in one single-port
// synchronous memory with registered read data. Requests: write entry
// (one result), read entry (one result), allocate a ten-cluster chain
// (scans from entry 0 one entry per cycle, then ten results with one link
// write each, or one no-space result if fewer than ten entries are free)
// and walk a chain (ten results). One request is worked on at a time, and
// results leave through an output register; the block waits to produce the
// next result while one is still held there.
// After reset the block sweeps the table to zero, one entry per cycle,
// and accepts no request meanwhile; csr writes are taken at any time but
// must only be issued while the block is idle.
module fat_chain_allocator (
   input  logic       clock,
   input  logic       reset,
   fca_req_if.sink    req_chan,
   fca_rsp_if.source  rsp_chan,
   fca_csr_if.sink    csr_chan
);

   // configuration registers
   logic [fca_pkg::CLUSTER_W-1:0] empty_marker_ff, empty_marker_in;
   logic [fca_pkg::CLUSTER_W-1:0] end_marker_ff, end_marker_in;

   fca_pkg::cfg_type              cfg;
   fca_pkg::mem_req_type          mem_req;
   logic [fca_pkg::CLUSTER_W-1:0] rd_data;

   // csr channel never stalls
   assign csr_chan.ready = 1'b1;

   always_comb begin
      empty_marker_in = empty_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            fca_pkg::CSR_EMPTY_MARKER: empty_marker_in = csr_chan.data;
            fca_pkg::CSR_END_MARKER:   end_marker_in   = csr_chan.data;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_marker_ff <= '0;
         end_marker_ff   <= '1;
      end else begin
         empty_marker_ff <= empty_marker_in;
         end_marker_ff   <= end_marker_in;
      end
   end

   assign cfg.empty_marker = empty_marker_ff;
   assign cfg.end_marker   = end_marker_ff;

   // request sequencer: clear sweep, scan, link, walk, output register
   fca_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .cfg     (cfg),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // link table storage
   fca_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* verif/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   fca_req_if req_bus ();
   fca_rsp_if rsp_bus ();
   fca_csr_if csr_bus ();

   fat_chain_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // shadow copy of the allocation table and both marker registers
   logic [fca_pkg::CLUSTER_W-1:0] fat_shadow [fca_pkg::TABLE_DEPTH];
   logic [fca_pkg::CLUSTER_W-1:0] empty_mark;
   logic [fca_pkg::CLUSTER_W-1:0] end_mark;

   // indices handed out by the most recent allocate request
   int                            chain_idx [fca_pkg::CHAIN_LENGTH];
   bit                            alloc_ok;

   // results still owed by the block, oldest first
   fca_pkg::rsp_item_type         pending_rsp [$];
   fca_pkg::rsp_item_type         want;

   int                            error_count = 0;
   int                            sent_count  = 0;
   int                            rsp_hold    = 0;
   // when set, neither side inserts idle cycles
   bit                            steady      = 1'b0;

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic void push_result(int pos, logic [fca_pkg::CLUSTER_W-1:0] clus,
                                       fca_pkg::status_code_type stat, bit fin);
      fca_pkg::rsp_item_type r;
      r.position = fca_pkg::POS_W'(pos);
      r.cluster  = clus;
      r.status   = stat;
      r.last     = fin;
      pending_rsp.push_back(r);
   endfunction

   // first ten free entries from the bottom, linked in order
   function automatic void predict_allocate();
      int count;
      count = 0;
      for (int i = 0; i < fca_pkg::TABLE_DEPTH && count < fca_pkg::CHAIN_LENGTH; i++) begin
         if (fat_shadow[i] == empty_mark) begin
            chain_idx[count] = i;
            count++;
         end
      end
      if (count < fca_pkg::CHAIN_LENGTH) begin
         // not enough room: table untouched, single failure result
         alloc_ok = 1'b0;
         push_result(0, '0, fca_pkg::STAT_NO_SPACE, 1'b1);
      end else begin
         alloc_ok = 1'b1;
         for (int i = 0; i + 1 < fca_pkg::CHAIN_LENGTH; i++)
            fat_shadow[chain_idx[i]] = fca_pkg::CLUSTER_W'(chain_idx[i+1]);
         fat_shadow[chain_idx[fca_pkg::CHAIN_LENGTH-1]] = end_mark;
         for (int i = 0; i < fca_pkg::CHAIN_LENGTH; i++)
            push_result(i, fca_pkg::CLUSTER_W'(chain_idx[i]), fca_pkg::STAT_OK,
                        i == fca_pkg::CHAIN_LENGTH - 1);
      end
   endfunction

   // follow links from the first cluster; a link past the table ends the walk
   function automatic void predict_walk(logic [fca_pkg::INDEX_W-1:0] first);
      logic [fca_pkg::CLUSTER_W-1:0] cur;
      bit                            broken;
      bit                            fin;
      cur    = fca_pkg::CLUSTER_W'(first);
      broken = 1'b0;
      push_result(0, cur, fca_pkg::STAT_OK, fca_pkg::CHAIN_LENGTH == 1);
      for (int i = 1; i < fca_pkg::CHAIN_LENGTH; i++) begin
         fin = (i == fca_pkg::CHAIN_LENGTH - 1);
         if (!broken && cur >= fca_pkg::DEPTH_C)
            broken = 1'b1;
         if (broken) begin
            push_result(i, '0, fca_pkg::STAT_OUT_OF_RANGE, fin);
         end else begin
            cur = fat_shadow[cur[fca_pkg::ADDR_W-1:0]];
            push_result(i, cur, fca_pkg::STAT_OK, fin);
         end
      end
   endfunction

   // a twelve-bit index always lands inside the table
   function automatic void predict_request(fca_pkg::req_code_type kind,
                                           logic [fca_pkg::INDEX_W-1:0] idx,
                                           logic [fca_pkg::CLUSTER_W-1:0] val);
      case (kind)
         fca_pkg::REQ_WRITE: begin
            fat_shadow[idx] = val;
            push_result(0, val, fca_pkg::STAT_OK, 1'b1);
         end
         fca_pkg::REQ_READ:  push_result(0, fat_shadow[idx], fca_pkg::STAT_OK, 1'b1);
         fca_pkg::REQ_ALLOC: predict_allocate();
         default:            predict_walk(idx);
      endcase
   endfunction

   // present one request, wait for acceptance, then idle for a drawn gap
   task automatic send_request(fca_pkg::req_code_type kind,
                               logic [fca_pkg::INDEX_W-1:0] idx,
                               logic [fca_pkg::CLUSTER_W-1:0] val);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.index    <= idx;
      req_bus.value    <= val;
      do @(posedge clock); while (!req_bus.ready);
      predict_request(kind, idx, val);
      sent_count++;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop the request line and let every owed result drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // leaves valid high; the caller drops it after the last write
   task automatic write_csr(fca_pkg::csr_code_type which,
                            logic [fca_pkg::CLUSTER_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= which;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (which == fca_pkg::CSR_EMPTY_MARKER)
         empty_mark = data;
      else
         end_mark = data;
   endtask

   task automatic set_markers(logic [fca_pkg::CLUSTER_W-1:0] empty_val,
                              logic [fca_pkg::CLUSTER_W-1:0] end_val);
      wait_idle();
      write_csr(fca_pkg::CSR_EMPTY_MARKER, empty_val);
      write_csr(fca_pkg::CSR_END_MARKER, end_val);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [fca_pkg::CLUSTER_W-1:0] pick_marker();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return {fca_pkg::CLUSTER_W{1'b1}};
         2:       return fca_pkg::CLUSTER_W'($urandom_range(0, fca_pkg::TABLE_DEPTH - 1));
         default: return fca_pkg::CLUSTER_W'($urandom);
      endcase
   endfunction

   // mostly low entries so writes, walks and allocations overlap
   function automatic logic [fca_pkg::INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 3) == 0)
         return fca_pkg::INDEX_W'($urandom);
      return fca_pkg::INDEX_W'($urandom_range(0, 63));
   endfunction

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no request pending: cluster %h", rsp_bus.cluster);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_bus.position);
               error_count++;
            end
            if (rsp_bus.cluster !== want.cluster) begin
               $error("cluster: expected %h, got %h", want.cluster, rsp_bus.cluster);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_bus.ready) begin
         // after each taken result, maybe stall for a drawn number of cycles
         if (rsp_bus.valid) begin
            rsp_hold = draw_gap();
            if (rsp_hold > 0) begin
               rsp_bus.ready <= 1'b0;
               rsp_hold--;
            end
         end
      end else if (rsp_hold == 0) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_hold--;
      end
   end

   // fresh table: all zero, zero is the free marker
   task automatic test_reset_state();
      send_request(fca_pkg::REQ_READ, '0, fca_pkg::CLUSTER_W'($urandom));
      send_request(fca_pkg::REQ_READ, {fca_pkg::INDEX_W{1'b1}}, fca_pkg::CLUSTER_W'($urandom));
      send_request(fca_pkg::REQ_WALK, {fca_pkg::INDEX_W{1'b1}}, '0);
   endtask

   // extreme indices and values, links just inside and just past the table
   task automatic test_entry_extremes();
      send_request(fca_pkg::REQ_WRITE, '0, {fca_pkg::CLUSTER_W{1'b1}});
      send_request(fca_pkg::REQ_WRITE, {fca_pkg::INDEX_W{1'b1}}, '0);
      send_request(fca_pkg::REQ_READ, '0, '0);
      send_request(fca_pkg::REQ_WRITE, fca_pkg::INDEX_W'(5), fca_pkg::DEPTH_C);
      send_request(fca_pkg::REQ_WALK, fca_pkg::INDEX_W'(5), '0);
      send_request(fca_pkg::REQ_WRITE, fca_pkg::INDEX_W'(6), fca_pkg::DEPTH_C - 1'b1);
      send_request(fca_pkg::REQ_WALK, fca_pkg::INDEX_W'(6), '0);
      send_request(fca_pkg::REQ_WRITE, 12'hAAA, 24'h555555);
      send_request(fca_pkg::REQ_WRITE, 12'h555, 24'hAAAAAA);
   endtask

   // successful allocation, walk from its head and from its tail
   task automatic test_allocate_chain();
      send_request(fca_pkg::REQ_ALLOC, fca_pkg::INDEX_W'($urandom),
                   fca_pkg::CLUSTER_W'($urandom));
      send_request(fca_pkg::REQ_WALK, fca_pkg::INDEX_W'(chain_idx[0]), '0);
      // tail holds the end marker, which lies outside the table
      send_request(fca_pkg::REQ_WALK,
                   fca_pkg::INDEX_W'(chain_idx[fca_pkg::CHAIN_LENGTH-1]), '0);
      send_request(fca_pkg::REQ_READ, fca_pkg::INDEX_W'(chain_idx[4]), '0);
   endtask

   // too few free entries: single failure result, table unchanged
   task automatic test_allocate_failure();
      set_markers(24'h5A5A5A, {fca_pkg::CLUSTER_W{1'b1}});
      send_request(fca_pkg::REQ_ALLOC, '0, '0);
      set_markers({fca_pkg::CLUSTER_W{1'b1}}, {fca_pkg::CLUSTER_W{1'b1}});
      send_request(fca_pkg::REQ_ALLOC, {fca_pkg::INDEX_W{1'b1}},
                   {fca_pkg::CLUSTER_W{1'b1}});
   endtask

   // end marker of zero points back into the table, so the walk goes on
   task automatic test_marker_extremes();
      set_markers('0, '0);
      send_request(fca_pkg::REQ_ALLOC, '0, '0);
      send_request(fca_pkg::REQ_WALK,
                   fca_pkg::INDEX_W'(chain_idx[fca_pkg::CHAIN_LENGTH-2]), '0);
   endtask

   // plant free markers, allocate, then walk, read and break the chain
   task automatic run_chain_sequence();
      int plant;
      int walks;
      plant = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 14) : 0;
      repeat (plant) send_request(fca_pkg::REQ_WRITE, pick_index(), empty_mark);
      send_request(fca_pkg::REQ_ALLOC, fca_pkg::INDEX_W'($urandom),
                   fca_pkg::CLUSTER_W'($urandom));
      if (alloc_ok) begin
         walks = $urandom_range(1, 3);
         repeat (walks)
            send_request(fca_pkg::REQ_WALK,
                         fca_pkg::INDEX_W'(chain_idx[$urandom_range(0,
                                           fca_pkg::CHAIN_LENGTH-1)]),
                         fca_pkg::CLUSTER_W'($urandom));
         if ($urandom_range(0, 1) == 1)
            send_request(fca_pkg::REQ_READ,
                         fca_pkg::INDEX_W'(chain_idx[$urandom_range(0,
                                           fca_pkg::CHAIN_LENGTH-1)]),
                         fca_pkg::CLUSTER_W'($urandom));
         if ($urandom_range(0, 1) == 1) begin
            // overwrite one link, then walk across the damage
            send_request(fca_pkg::REQ_WRITE,
                         fca_pkg::INDEX_W'(chain_idx[$urandom_range(1,
                                           fca_pkg::CHAIN_LENGTH-2)]),
                         ($urandom_range(0, 1) == 1)
                            ? fca_pkg::CLUSTER_W'($urandom)
                            : fca_pkg::CLUSTER_W'($urandom_range(0, 63)));
            send_request(fca_pkg::REQ_WALK, fca_pkg::INDEX_W'(chain_idx[0]), '0);
         end
      end
   endtask

   // hand-built chain of a few links among the low entries
   task automatic run_link_sequence();
      logic [fca_pkg::INDEX_W-1:0] head;
      logic [fca_pkg::INDEX_W-1:0] node;
      logic [fca_pkg::INDEX_W-1:0] next_node;
      int                          links;
      head  = fca_pkg::INDEX_W'($urandom_range(0, 63));
      node  = head;
      links = $urandom_range(2, 5);
      repeat (links) begin
         next_node = fca_pkg::INDEX_W'($urandom_range(0, 63));
         send_request(fca_pkg::REQ_WRITE, node,
                      ($urandom_range(0, 4) == 0) ? fca_pkg::CLUSTER_W'($urandom)
                                                  : fca_pkg::CLUSTER_W'(next_node));
         node = next_node;
      end
      send_request(fca_pkg::REQ_WALK, head, fca_pkg::CLUSTER_W'($urandom));
   endtask

   task automatic test_random_traffic();
      int cfg_mark;
      cfg_mark = sent_count;
      while (sent_count < 140) begin
         if (sent_count - cfg_mark >= 30) begin
            set_markers(($urandom_range(0, 2) == 0) ? '0 : pick_marker(), pick_marker());
            cfg_mark = sent_count;
         end
         if ($urandom_range(0, 5) == 0)
            steady = ~steady;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: run_chain_sequence();
            4, 5, 6:    send_request(fca_pkg::req_code_type'($urandom_range(0, 3)),
                                     pick_index(),
                                     ($urandom_range(0, 1) == 1)
                                        ? fca_pkg::CLUSTER_W'($urandom)
                                        : fca_pkg::CLUSTER_W'($urandom_range(0,
                                             fca_pkg::TABLE_DEPTH - 1)));
            default:    run_link_sequence();
         endcase
      end
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.req_type = fca_pkg::REQ_WRITE;
      req_bus.index    = '0;
      req_bus.value    = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = fca_pkg::CSR_EMPTY_MARKER;
      csr_bus.data     = '0;
      rsp_bus.ready    = 1'b0;
      // reset state of the shadow table and markers
      empty_mark = '0;
      end_mark   = {fca_pkg::CLUSTER_W{1'b1}};
      alloc_ok   = 1'b0;
      foreach (fat_shadow[i]) fat_shadow[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // the block clears its table before taking the first request
      test_reset_state();
      test_entry_extremes();
      test_allocate_chain();
      test_allocate_failure();
      test_marker_extremes();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #24000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* fat_chain_allocator.f */
sv/fca_pkg.sv
sv/fca_if.sv
sv/fca_ram.sv
sv/fca_seq.sv
sv/fat_chain_allocator.sv
verif/tb_top.sv
